// ===== hw/rtl/bbte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbte_pkg
// Shared types and constants of the block-transfer engine.
// ----------------------------------------------------------------------------
package bbte_pkg;

   localparam int WORD_BITS      = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [WORD_BITS-1:0] FULL_WORD = 16'hFFFF;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_X_STEP     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_Y_STEP     = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_X_STEP     = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_Y_STEP     = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_FIRST     = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_LAST      = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOGIC_OP       = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_SELECT  = 4'd7;

   // control handed to the raster-op unit
   typedef struct packed {
      logic [3:0]           logic_op;
      logic                 source_select;
      logic [WORD_BITS-1:0] mask;
   } rop_ctrl_type;

endpackage

// ===== hw/rtl/bbte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbte_req_if / bbte_rsp_if / bbte_csr_if
// Valid/ready channels of the block-transfer engine.
// ----------------------------------------------------------------------------
interface bbte_req_if #(
   parameter int ADDR_BITS = 24
);
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [ADDR_BITS-1:0] src_start_addr;
   logic [ADDR_BITS-1:0] dst_start_addr;
   logic [15:0]          words_per_line;
   logic [15:0]          line_count;
   logic [15:0]          src_word;
   logic [15:0]          dst_word;

   modport source (output valid, req_type, src_start_addr, dst_start_addr,
                   words_per_line, line_count, src_word, dst_word,
                   input ready);
   modport sink   (input valid, req_type, src_start_addr, dst_start_addr,
                   words_per_line, line_count, src_word, dst_word,
                   output ready);
endinterface

interface bbte_rsp_if #(
   parameter int ADDR_BITS = 24
);
   logic                 valid;
   logic                 ready;
   logic                 write_enable;
   logic [ADDR_BITS-1:0] write_addr;
   logic [15:0]          write_data;
   logic [ADDR_BITS-1:0] next_src_addr;
   logic [ADDR_BITS-1:0] next_dst_addr;
   logic                 done_res;

   modport source (output valid, write_enable, write_addr, write_data,
                   next_src_addr, next_dst_addr, done_res,
                   input ready);
   modport sink   (input valid, write_enable, write_addr, write_data,
                   next_src_addr, next_dst_addr, done_res,
                   output ready);
endinterface

interface bbte_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bbte_rop.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbte_rop
// Truth-table raster operation and end-mask merge for one word.
// ----------------------------------------------------------------------------
module bbte_rop (
   input  bbte_pkg::rop_ctrl_type ctrl,
   input  logic [15:0]            src_word,
   input  logic [15:0]            dst_word,
   output logic [15:0]            merged_word
);
   import bbte_pkg::*;

   logic [WORD_BITS-1:0] src_operand;
   logic [WORD_BITS-1:0] op_result;

   assign src_operand = ctrl.source_select ? src_word : FULL_WORD;

   // each bit picks a truth-table entry by {not src, not dst}
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         op_result[b] = ctrl.logic_op[{~src_operand[b], ~dst_word[b]}];
      end
   end

   assign merged_word = (op_result & ctrl.mask) | (dst_word & ~ctrl.mask);

endmodule

// ===== hw/rtl/bitplane_block_transfer_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitplane_block_transfer_engine
// Rectangle block-transfer engine: raster op, end masks and address walk.
// ----------------------------------------------------------------------------
// Use:
//  - csr_chan writes the step, mask, op and source-select registers; it is
//    always ready. Write only while no item is in flight.
//  - req_chan takes items: a start item loads addresses, words per line and
//    line count; each data item brings the source and destination words
//    found at the addresses reported by the previous result.
//  - rsp_chan gives exactly one item per request: the write (enable,
//    address, merged data), the next source/destination addresses and done.
// Timing:
//  - Two register stages: input register, then result register. A request
//    is accepted into the input register and moves on into the result
//    register, where its result is valid, once that one is free or read.
//  - Throughput is 1 item per cycle while rsp_chan.ready stays high; the
//    walk state updates as each item moves from input to result register.
//  - When the receiver stalls, the result register holds, then the input
//    register; req_chan.ready drops once both are full.
// Reset (synchronous): pipeline emptied, registers to their defaults,
//  addresses zero and no lines pending (data items then write nothing).
// ----------------------------------------------------------------------------
module bitplane_block_transfer_engine #(
   parameter int ADDR_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   bbte_csr_if.sink                 csr_chan,
   bbte_req_if.sink                 req_chan,
   bbte_rsp_if.source               rsp_chan
);
   import bbte_pkg::*;

   // ---------------------------------------------------------------- config
   logic signed [15:0] src_x_step_ff, src_y_step_ff, dst_x_step_ff, dst_y_step_ff;
   logic [15:0]        mask_first_ff, mask_last_ff;
   logic [3:0]         logic_op_ff;
   logic               source_select_ff;
   logic               csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid & csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_x_step_ff    <= 16'sd2;
         src_y_step_ff    <= 16'sd2;
         dst_x_step_ff    <= 16'sd8;
         dst_y_step_ff    <= 16'sd8;
         mask_first_ff    <= FULL_WORD;
         mask_last_ff     <= FULL_WORD;
         logic_op_ff      <= 4'd3;
         source_select_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_chan.index)
            CSR_SRC_X_STEP:    src_x_step_ff    <= csr_chan.data;
            CSR_SRC_Y_STEP:    src_y_step_ff    <= csr_chan.data;
            CSR_DST_X_STEP:    dst_x_step_ff    <= csr_chan.data;
            CSR_DST_Y_STEP:    dst_y_step_ff    <= csr_chan.data;
            CSR_MASK_FIRST:    mask_first_ff    <= csr_chan.data;
            CSR_MASK_LAST:     mask_last_ff     <= csr_chan.data;
            CSR_LOGIC_OP:      logic_op_ff      <= csr_chan.data[3:0];
            CSR_SOURCE_SELECT: source_select_ff <= csr_chan.data[0];
            default: ; // unused indexes are ignored
         endcase
      end
   end

   // ---------------------------------------------------------- handshakes
   logic in_vld_ff, out_vld_ff;
   logic advance;   // input register moves into result register
   logic req_take;

   assign advance        = in_vld_ff & (~out_vld_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_vld_ff | advance;
   assign req_take       = req_chan.valid & req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------ input register
   logic                 req_type_ff;
   logic [ADDR_BITS-1:0] src_start_ff, dst_start_ff;
   logic [15:0]          words_per_line_ff, line_count_ff;
   logic [15:0]          src_word_ff, dst_word_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_type_ff       <= req_chan.req_type;
         src_start_ff      <= req_chan.src_start_addr;
         dst_start_ff      <= req_chan.dst_start_addr;
         words_per_line_ff <= req_chan.words_per_line;
         line_count_ff     <= req_chan.line_count;
         src_word_ff       <= req_chan.src_word;
         dst_word_ff       <= req_chan.dst_word;
      end
   end

   // ---------------------------------------------------------- walk state
   logic [ADDR_BITS-1:0] cur_src_ff, cur_src_in;
   logic [ADDR_BITS-1:0] cur_dst_ff, cur_dst_in;
   logic [15:0]          line_words_ff, line_words_in;
   logic [15:0]          word_index_ff, word_index_in;
   logic [15:0]          lines_left_ff, lines_left_in;

   logic                 is_data, busy, is_last;
   logic [15:0]          last_idx;
   logic [ADDR_BITS-1:0] src_step, dst_step;
   rop_ctrl_type         rop_ctrl;
   logic [15:0]          merged_word;

   assign is_data  = (req_type_ff == REQ_DATA);
   assign busy     = (lines_left_ff != 16'd0);
   assign last_idx = line_words_ff - 16'd1;
   assign is_last  = (word_index_ff == last_idx);

   // steps sign-extended to the address width; sum wraps naturally
   assign src_step = is_last ? ADDR_BITS'(src_y_step_ff) : ADDR_BITS'(src_x_step_ff);
   assign dst_step = is_last ? ADDR_BITS'(dst_y_step_ff) : ADDR_BITS'(dst_x_step_ff);

   always_comb begin
      rop_ctrl.logic_op      = logic_op_ff;
      rop_ctrl.source_select = source_select_ff;
      // one-word line: both end masks at once
      priority if (word_index_ff == 16'd0) begin
         rop_ctrl.mask = (line_words_ff == 16'd1) ? (mask_first_ff & mask_last_ff)
                                                  : mask_first_ff;
      end else if (is_last) begin
         rop_ctrl.mask = mask_last_ff;
      end else begin
         rop_ctrl.mask = FULL_WORD;
      end
   end

   bbte_rop u_rop (
      .ctrl        (rop_ctrl),
      .src_word    (src_word_ff),
      .dst_word    (dst_word_ff),
      .merged_word (merged_word)
   );

   always_comb begin
      cur_src_in    = cur_src_ff;
      cur_dst_in    = cur_dst_ff;
      line_words_in = line_words_ff;
      word_index_in = word_index_ff;
      lines_left_in = lines_left_ff;
      if (!is_data) begin
         // start abandons any running operation
         cur_src_in    = src_start_ff;
         cur_dst_in    = dst_start_ff;
         line_words_in = words_per_line_ff;
         lines_left_in = line_count_ff;
         word_index_in = 16'd0;
      end else if (busy) begin
         cur_src_in = cur_src_ff + src_step;
         cur_dst_in = cur_dst_ff + dst_step;
         if (is_last) begin
            word_index_in = 16'd0;
            lines_left_in = lines_left_ff - 16'd1;
         end else begin
            word_index_in = word_index_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_src_ff    <= '0;
         cur_dst_ff    <= '0;
         line_words_ff <= 16'd1;
         word_index_ff <= 16'd0;
         lines_left_ff <= 16'd0;
      end else if (advance) begin
         cur_src_ff    <= cur_src_in;
         cur_dst_ff    <= cur_dst_in;
         line_words_ff <= line_words_in;
         word_index_ff <= word_index_in;
         lines_left_ff <= lines_left_in;
      end
   end

   // ----------------------------------------------------- result register
   logic                 write_enable_ff;
   logic [ADDR_BITS-1:0] write_addr_ff;
   logic [15:0]          write_data_ff;
   logic [ADDR_BITS-1:0] next_src_ff, next_dst_ff;
   logic                 done_ff;
   logic                 writes;

   assign writes = is_data & busy;

   always_ff @(posedge clock) begin
      if (advance) begin
         write_enable_ff <= writes;
         write_addr_ff   <= writes ? cur_dst_ff : '0;
         write_data_ff   <= writes ? merged_word : 16'd0;
         next_src_ff     <= cur_src_in;
         next_dst_ff     <= cur_dst_in;
         done_ff         <= (lines_left_in == 16'd0);
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.write_enable  = write_enable_ff;
   assign rsp_chan.write_addr    = write_addr_ff;
   assign rsp_chan.write_data    = write_data_ff;
   assign rsp_chan.next_src_addr = next_src_ff;
   assign rsp_chan.next_dst_addr = next_dst_ff;
   assign rsp_chan.done_res      = done_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rectangle block-transfer engine.
// A short directed table is driven first: idle data items, zero-line and
// one-word blocks, address wrap, every end mask, several raster ops and
// step extremes. Random blocks follow under a new register setting per
// phase. Each result is taken from the table row if given, else from an
// in-bench model of op, masks and address walk, compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
   import bbte_pkg::*;

   localparam int ADDR_BITS   = 24;
   localparam int ITEM_TARGET = 1150;     // random items after the table
   localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
   localparam int PRINT_LIMIT = 40;       // mismatch lines shown, all counted

   typedef struct packed {
      logic                 req_type;
      logic [ADDR_BITS-1:0] src_start_addr;
      logic [ADDR_BITS-1:0] dst_start_addr;
      logic [15:0]          words_per_line;
      logic [15:0]          line_count;
      logic [15:0]          src_word;
      logic [15:0]          dst_word;
   } blit_req_t;

   typedef struct packed {
      logic                 write_enable;
      logic [ADDR_BITS-1:0] write_addr;
      logic [15:0]          write_data;
      logic [ADDR_BITS-1:0] next_src_addr;
      logic [ADDR_BITS-1:0] next_dst_addr;
      logic                 done_res;
   } blit_rsp_t;

   // one row of the directed table: an item to send or a register to write
   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

   typedef struct {
      row_kind_t   kind;
      logic [3:0]  reg_index;
      logic [15:0] reg_value;
      blit_req_t   item;
      bit          typed;     // expected result written into the row
      blit_rsp_t   want;
   } plan_row_t;

   logic clock;
   logic reset;

   bbte_csr_if                          csr_chan ();
   bbte_req_if #(.ADDR_BITS(ADDR_BITS)) req_chan ();
   bbte_rsp_if #(.ADDR_BITS(ADDR_BITS)) rsp_chan ();

   bitplane_block_transfer_engine #(.ADDR_BITS(ADDR_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // --- bench copy of the registers ---
   logic [15:0] cfg_src_x_step, cfg_src_y_step, cfg_dst_x_step, cfg_dst_y_step;
   logic [15:0] cfg_mask_first, cfg_mask_last;
   logic [3:0]  cfg_logic_op;
   logic        cfg_source_select;

   // --- bench copy of the address walk ---
   logic [ADDR_BITS-1:0] walk_src, walk_dst;
   logic [15:0]          walk_line_words, walk_index, walk_lines_left;

   blit_rsp_t predicted_writes[$];   // results still owed by the engine, oldest first
   plan_row_t plan[$];

   int idle_level;                   // 0: both sides run flat out
   int stall_left;
   int cycles, mismatches;
   int items_sent, directed_items, results_seen, words_written, starts_sent;
   int reg_writes, phases;

   // ------------------------------------------------------------------------
   // clock, cycle limit
   // ------------------------------------------------------------------------
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results outstanding",
                  cycles, predicted_writes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------------
   task automatic flag_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                 results_seen, name, got, want));
   endtask

   // mostly no pause, now and then a short one, rarely a long one
   function automatic int pause_length();
      int roll;
      if (idle_level == 0)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return 0;
      if (roll < 96)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ADDR_BITS-1:0] to_addr_step(input logic [15:0] s);
      return {{(ADDR_BITS-16){s[15]}}, s};
   endfunction

   // ------------------------------------------------------------------------
   // predictor: raster op, end mask and address walk for one item
   // ------------------------------------------------------------------------
   function automatic blit_rsp_t rop_walk_step(input blit_req_t r);
      blit_rsp_t   o;
      logic [15:0] operand, combined, end_mask, last_index;
      logic [1:0]  sel;
      bit          at_last;
      o = '0;
      if (r.req_type == REQ_START) begin
         // a start drops whatever block was running
         walk_src        = r.src_start_addr;
         walk_dst        = r.dst_start_addr;
         walk_line_words = r.words_per_line;
         walk_lines_left = r.line_count;
         walk_index      = '0;
      end else if (walk_lines_left != 0) begin
         operand = cfg_source_select ? r.src_word : FULL_WORD;
         for (int b = 0; b < 16; b++) begin
            sel         = {~operand[b], ~r.dst_word[b]};
            combined[b] = cfg_logic_op[sel];
         end
         // zero words per line wraps to a 65536-word line
         last_index = walk_line_words - 16'd1;
         at_last    = (walk_index == last_index);
         if (walk_index == 16'd0)
            end_mask = (walk_line_words == 16'd1) ? (cfg_mask_first & cfg_mask_last)
                                                  : cfg_mask_first;
         else if (at_last)
            end_mask = cfg_mask_last;
         else
            end_mask = FULL_WORD;
         o.write_enable = 1'b1;
         o.write_addr   = walk_dst;
         o.write_data   = (combined & end_mask) | (r.dst_word & ~end_mask);
         // y step applies after every last word, the final line's too
         if (at_last) begin
            walk_src        = walk_src + to_addr_step(cfg_src_y_step);
            walk_dst        = walk_dst + to_addr_step(cfg_dst_y_step);
            walk_index      = '0;
            walk_lines_left = walk_lines_left - 16'd1;
         end else begin
            walk_src   = walk_src + to_addr_step(cfg_src_x_step);
            walk_dst   = walk_dst + to_addr_step(cfg_dst_x_step);
            walk_index = walk_index + 16'd1;
         end
      end
      o.next_src_addr = walk_src;
      o.next_dst_addr = walk_dst;
      o.done_res      = (walk_lines_left == 16'd0);
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic issue(input blit_req_t r, input bit typed, input blit_rsp_t want);
      int        gap;
      blit_rsp_t model;
      gap = pause_length();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.req_type       <= r.req_type;
      req_chan.src_start_addr <= r.src_start_addr;
      req_chan.dst_start_addr <= r.dst_start_addr;
      req_chan.words_per_line <= r.words_per_line;
      req_chan.line_count     <= r.line_count;
      req_chan.src_word       <= r.src_word;
      req_chan.dst_word       <= r.dst_word;
      do @(posedge clock); while (!req_chan.ready);
      // item taken at this edge; the model moves on with it
      model = rop_walk_step(r);
      predicted_writes.push_back(typed ? want : model);
      items_sent++;
      if (r.req_type == REQ_START)
         starts_sent++;
   endtask

   // hold the sender until every owed result is back, plus the pipe depth
   task automatic wait_until_idle();
      req_chan.valid <= 1'b0;
      while (predicted_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves valid high; the caller lowers it after the last write of a group
   task automatic set_reg(input logic [3:0] idx, input logic [15:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_SRC_X_STEP:    cfg_src_x_step    = val;
         CSR_SRC_Y_STEP:    cfg_src_y_step    = val;
         CSR_DST_X_STEP:    cfg_dst_x_step    = val;
         CSR_DST_Y_STEP:    cfg_dst_y_step    = val;
         CSR_MASK_FIRST:    cfg_mask_first    = val;
         CSR_MASK_LAST:     cfg_mask_last     = val;
         CSR_LOGIC_OP:      cfg_logic_op      = val[3:0];
         CSR_SOURCE_SELECT: cfg_source_select = val[0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // ------------------------------------------------------------------------
   // random content
   // ------------------------------------------------------------------------
   function automatic logic [15:0] word_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return 16'h0000;
      if (roll == 1)
         return 16'hFFFF;
      return $urandom;
   endfunction

   function automatic logic [15:0] step_value();
      case ($urandom_range(0, 6))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4, 5:    return $urandom_range(0, 32) - 16;
         default: return $urandom;
      endcase
   endfunction

   // every field random; callers pin what matters
   function automatic blit_req_t noise_item();
      blit_req_t r;
      r.req_type       = $urandom;
      r.src_start_addr = $urandom;
      r.dst_start_addr = $urandom;
      r.words_per_line = $urandom;
      r.line_count     = $urandom;
      r.src_word       = word_value();
      r.dst_word       = word_value();
      return r;
   endfunction

   task automatic randomise_regs();
      set_reg(CSR_SRC_X_STEP, step_value());
      set_reg(CSR_SRC_Y_STEP, step_value());
      set_reg(CSR_DST_X_STEP, step_value());
      set_reg(CSR_DST_Y_STEP, step_value());
      set_reg(CSR_MASK_FIRST, ($urandom_range(0, 3) == 0) ? FULL_WORD : word_value());
      set_reg(CSR_MASK_LAST,  ($urandom_range(0, 3) == 0) ? FULL_WORD : word_value());
      set_reg(CSR_LOGIC_OP, $urandom_range(0, 15));
      set_reg(CSR_SOURCE_SELECT, $urandom_range(0, 1));
      csr_chan.valid <= 1'b0;
   endtask

   // one start item and the data items of its block, sometimes bent
   task automatic run_random_block();
      blit_req_t r;
      longint    total;
      int        send, pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         issue(noise_item(), 1'b0, '0);
         return;
      end
      r = noise_item();
      r.req_type = REQ_START;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         r.words_per_line = $urandom_range(1, 6);
      else if (pick < 86)
         r.words_per_line = 16'd0;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         r.line_count = $urandom_range(1, 5);
      else if (pick < 86)
         r.line_count = 16'd0;
      total = (r.words_per_line == 16'd0 ? 65536 : longint'(r.words_per_line))
              * longint'(r.line_count);
      if (total > 48) begin
         send = $urandom_range(1, 12);    // cut short by the next start
      end else begin
         send = int'(total);
         pick = $urandom_range(0, 99);
         if (pick < 10 && send > 0)
            send = $urandom_range(0, send - 1);
         else if (pick < 30)
            send += $urandom_range(1, 2); // data items after done
      end
      issue(r, 1'b0, '0);
      repeat (send) begin
         r = noise_item();
         r.req_type = REQ_DATA;
         issue(r, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------------
   // directed table rows
   // ------------------------------------------------------------------------
   function automatic plan_row_t start_row(input logic [ADDR_BITS-1:0] src,
                                           input logic [ADDR_BITS-1:0] dst,
                                           input logic [15:0] wpl,
                                           input logic [15:0] lines);
      plan_row_t row;
      row = '{kind: ROW_ITEM, reg_index: '0, reg_value: '0, item: noise_item(),
              typed: 1'b0, want: '0};
      row.item.req_type       = REQ_START;
      row.item.src_start_addr = src;
      row.item.dst_start_addr = dst;
      row.item.words_per_line = wpl;
      row.item.line_count     = lines;
      return row;
   endfunction

   function automatic plan_row_t data_row(input logic [15:0] sw, input logic [15:0] dw);
      plan_row_t row;
      row = '{kind: ROW_ITEM, reg_index: '0, reg_value: '0, item: noise_item(),
              typed: 1'b0, want: '0};
      row.item.req_type = REQ_DATA;
      row.item.src_word = sw;
      row.item.dst_word = dw;
      return row;
   endfunction

   function automatic plan_row_t reg_row(input logic [3:0] idx, input logic [15:0] val);
      plan_row_t row;
      row = '{kind: ROW_REG, reg_index: idx, reg_value: val, item: '0,
              typed: 1'b0, want: '0};
      return row;
   endfunction

   function automatic plan_row_t expecting(input plan_row_t row, input logic we,
                                           input logic [ADDR_BITS-1:0] waddr,
                                           input logic [15:0] wdata,
                                           input logic [ADDR_BITS-1:0] nsrc,
                                           input logic [ADDR_BITS-1:0] ndst,
                                           input logic done);
      row.typed = 1'b1;
      row.want  = '{write_enable: we, write_addr: waddr, write_data: wdata,
                    next_src_addr: nsrc, next_dst_addr: ndst, done_res: done};
      return row;
   endfunction

   // ------------------------------------------------------------------------
   // result side: random back-pressure and in-order checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_left = pause_length();
         rsp_chan.ready <= (stall_left == 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   always @(posedge clock) begin
      blit_rsp_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_writes.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with none owed", results_seen));
         end else begin
            want = predicted_writes.pop_front();
            compare_field("write_enable",  rsp_chan.write_enable,  want.write_enable);
            compare_field("write_addr",    rsp_chan.write_addr,    want.write_addr);
            compare_field("write_data",    rsp_chan.write_data,    want.write_data);
            compare_field("next_src_addr", rsp_chan.next_src_addr, want.next_src_addr);
            compare_field("next_dst_addr", rsp_chan.next_dst_addr, want.next_dst_addr);
            compare_field("done_res",      rsp_chan.done_res,      want.done_res);
         end
         if (rsp_chan.write_enable === 1'b1)
            words_written++;
         results_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int next_phase_at;

      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.req_type       = REQ_START;
      req_chan.src_start_addr = '0;
      req_chan.dst_start_addr = '0;
      req_chan.words_per_line = '0;
      req_chan.line_count     = '0;
      req_chan.src_word       = '0;
      req_chan.dst_word       = '0;
      csr_chan.valid          = 1'b0;
      csr_chan.index          = CSR_SRC_X_STEP;
      csr_chan.data           = '0;
      rsp_chan.ready          = 1'b0;

      // register defaults and walk state after reset
      cfg_src_x_step    = 16'd2;
      cfg_src_y_step    = 16'd2;
      cfg_dst_x_step    = 16'd8;
      cfg_dst_y_step    = 16'd8;
      cfg_mask_first    = FULL_WORD;
      cfg_mask_last     = FULL_WORD;
      cfg_logic_op      = 4'd3;
      cfg_source_select = 1'b1;
      walk_src          = '0;
      walk_dst          = '0;
      walk_line_words   = 16'd1;
      walk_index        = '0;
      walk_lines_left   = '0;
      idle_level        = 1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed table ---
      // idle after reset: nothing written, addresses zero, done
      plan.push_back(expecting(data_row(16'h1234, 16'h5678),
                               1'b0, '0, '0, 24'h000000, 24'h000000, 1'b1));
      // zero line count reports done at once and leaves data items idle
      plan.push_back(expecting(start_row(24'hFFFFFF, 24'h000000, 16'd1, 16'd0),
                               1'b0, '0, '0, 24'hFFFFFF, 24'h000000, 1'b1));
      plan.push_back(expecting(data_row(16'hFFFF, 16'hFFFF),
                               1'b0, '0, '0, 24'hFFFFFF, 24'h000000, 1'b1));
      // 2x2 copy at the top of the address space; first step wraps to zero
      plan.push_back(expecting(start_row(24'hFFFFFE, 24'hFFFFF8, 16'd2, 16'd2),
                               1'b0, '0, '0, 24'hFFFFFE, 24'hFFFFF8, 1'b0));
      plan.push_back(expecting(data_row(16'hFFFF, 16'h0000),
                               1'b1, 24'hFFFFF8, 16'hFFFF, 24'h000000, 24'h000000, 1'b0));
      plan.push_back(data_row(16'h0000, 16'hFFFF));
      plan.push_back(data_row(16'hA5A5, 16'h5A5A));
      plan.push_back(data_row(16'h0F0F, 16'hF0F0));
      // XOR, narrow end masks, most negative and positive steps
      plan.push_back(reg_row(CSR_MASK_FIRST, 16'h00F0));
      plan.push_back(reg_row(CSR_MASK_LAST,  16'h0FF0));
      plan.push_back(reg_row(CSR_LOGIC_OP,   4'd6));
      plan.push_back(reg_row(CSR_SRC_X_STEP, 16'h8000));
      plan.push_back(reg_row(CSR_SRC_Y_STEP, 16'h7FFF));
      plan.push_back(reg_row(CSR_DST_X_STEP, 16'hFFFE));
      plan.push_back(reg_row(CSR_DST_Y_STEP, 16'h0000));
      // one-word line: both masks apply together
      plan.push_back(start_row(24'h000100, 24'h800000, 16'd1, 16'd1));
      plan.push_back(data_row(16'hFFFF, 16'h1234));
      // first, middle and last word of one line
      plan.push_back(start_row(24'h7FFFFF, 24'h000001, 16'd3, 16'd1));
      plan.push_back(data_row(16'hFFFF, 16'h0000));
      plan.push_back(data_row(16'h1357, 16'hFFFF));
      plan.push_back(data_row(16'h0000, 16'hFFFF));
      // clear op with the all-ones source operand
      plan.push_back(reg_row(CSR_LOGIC_OP,      4'd0));
      plan.push_back(reg_row(CSR_SOURCE_SELECT, 1'b0));
      plan.push_back(start_row(24'h000000, 24'h000000, 16'd2, 16'd1));
      plan.push_back(data_row(16'h0000, 16'hFFFF));
      plan.push_back(data_row(16'h0000, 16'hC33C));
      // AND; zero words per line (65536-word line), abandoned by a new start
      plan.push_back(reg_row(CSR_LOGIC_OP,      4'd1));
      plan.push_back(reg_row(CSR_SOURCE_SELECT, 1'b1));
      plan.push_back(reg_row(CSR_MASK_FIRST,    16'h0000));
      plan.push_back(reg_row(CSR_MASK_LAST,     16'hFFFF));
      plan.push_back(start_row(24'h123456, 24'hABCDEF, 16'd0, 16'd1));
      plan.push_back(data_row(16'hF0F0, 16'hFFFF));
      plan.push_back(data_row(16'hF0F0, 16'hFFFF));
      plan.push_back(start_row(24'h000002, 24'hFFFFFE, 16'd1, 16'hFFFF));
      plan.push_back(data_row(16'h8001, 16'hFFFF));
      // set-all op, remaining step extremes, a 65535-word line
      plan.push_back(reg_row(CSR_LOGIC_OP,   4'd15));
      plan.push_back(reg_row(CSR_SRC_X_STEP, 16'h7FFF));
      plan.push_back(reg_row(CSR_SRC_Y_STEP, 16'h8000));
      plan.push_back(reg_row(CSR_DST_X_STEP, 16'h0001));
      plan.push_back(reg_row(CSR_DST_Y_STEP, 16'hFFFF));
      plan.push_back(reg_row(CSR_MASK_FIRST, 16'hFFFF));
      plan.push_back(reg_row(CSR_MASK_LAST,  16'h0000));
      plan.push_back(start_row(24'h555555, 24'hAAAAAA, 16'hFFFF, 16'd1));
      plan.push_back(data_row(16'h0000, 16'h0000));
      plan.push_back(data_row(16'hFFFF, 16'h0000));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            if (i == 0 || plan[i-1].kind != ROW_REG)
               wait_until_idle();
            set_reg(plan[i].reg_index, plan[i].reg_value);
            if (i == plan.size() - 1 || plan[i+1].kind != ROW_REG)
               csr_chan.valid <= 1'b0;
         end else begin
            issue(plan[i].item, plan[i].typed, plan[i].want);
         end
      end
      directed_items = items_sent;

      // --- random phases, each under its own register setting ---
      next_phase_at = items_sent;
      while (items_sent < directed_items + ITEM_TARGET) begin
         if (items_sent >= next_phase_at) begin
            wait_until_idle();
            randomise_regs();
            idle_level    = ($urandom_range(0, 3) == 0) ? 0 : 1;
            next_phase_at = items_sent + $urandom_range(100, 200);
            phases++;
         end else if ($urandom_range(0, 99) < 3) begin
            // sender holds back until the engine has handed everything over
            wait_until_idle();
         end
         run_random_block();
      end

      wait_until_idle();
      repeat (8) @(posedge clock);

      $display("Sent %0d items (%0d from the table), %0d block starts, %0d register writes",
               items_sent, directed_items, starts_sent, reg_writes);
      $display("Checked %0d results, %0d of them word writes, over %0d random settings",
               results_seen, words_written, phases);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/bbte_pkg.sv
hw/rtl/bbte_if.sv
hw/rtl/bbte_rop.sv
hw/rtl/bitplane_block_transfer_engine.sv
tb/testbench.sv
